>>> rtl/core/lrf_pkg.sv
`default_nettype none

package lrf_pkg;

	localparam int SCREEN_WIDTH  = 200;
	localparam int SCREEN_HEIGHT = 150;
	localparam int FB_DEPTH      = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W        = $clog2(FB_DEPTH);

	typedef enum logic [2:0] {
		OP_HLINE   = 3'd0,
		OP_VLINE   = 3'd1,
		OP_RECT    = 3'd2,
		OP_OUTLINE = 3'd3,
		OP_CLEAR   = 3'd4,
		OP_READ    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DRAW,
		ST_CLR,
		ST_RD,
		ST_RDW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic              wdata;
		logic [ADDR_W-1:0] waddr;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/line_and_rect_fill_engine.sv
`default_nettype none

// Draws axis-aligned lines, filled rectangles and outlines into a one-bit
// 200 x 150 frame store, clears it, or reads one pixel; each request gives
// one result. The frame store takes one pixel write per cycle; draws and
// reads share a single address unit, and the block takes no new request
// until the current one has finished. Pixels off the screen are still
// walked through, but not written. After reset a clearing pass over the
// whole frame store runs before the first request is taken. A finished
// result waits in the output register while the next request is accepted.
module line_and_rect_fill_engine
	import lrf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] opcode,
	input  wire logic [7:0] start_x,
	input  wire logic [7:0] start_y,
	input  wire logic [7:0] span_length,
	input  wire logic [7:0] span_height,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            read_pixel,
	output logic            off_screen
);

	state_t state_q, state_d;

	logic [2:0]        op_q;
	logic [7:0]        x_q, y_q, len_q, hgt_q;
	logic [7:0]        ix_q, iy_q;
	logic [1:0]        seg_q;
	logic [ADDR_W-1:0] clr_q;
	logic              res_pix_q, res_off_q;
	logic              out_valid_q;

	logic       in_acc, out_take, load_res;
	logic [7:0] ex, ey;
	logic [8:0] base_x, base_y, px, py;
	logic       on_screen, last_seg, clr_last;
	logic       rdata;
	ram_ctl_t   ram_ctl;

	assign in_acc   = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign clr_last = (clr_q == ADDR_W'(FB_DEPTH - 1));

	// segment geometry; the outline walks four segments
	always_comb begin
		base_x   = {1'b0, x_q};
		base_y   = {1'b0, y_q};
		ex       = len_q;
		ey       = hgt_q;
		last_seg = 1'b1;
		case (op_q)
			OP_HLINE: ey = '0;
			OP_VLINE: ex = '0;
			OP_OUTLINE: begin
				last_seg = (seg_q == 2'd3);
				if (seg_q[0]) ex = '0;
				else ey = '0;
				if (seg_q == 2'd1) base_x = {1'b0, x_q} + {1'b0, len_q};
				if (seg_q == 2'd2) base_y = {1'b0, y_q} + {1'b0, hgt_q};
			end
			default: ;
		endcase
	end

	// shared address unit for draws and reads
	assign px        = base_x + {1'b0, ix_q};
	assign py        = base_y + {1'b0, iy_q};
	assign on_screen = (px < 9'(SCREEN_WIDTH)) && (py < 9'(SCREEN_HEIGHT));

	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b1;
		load_res      = 1'b0;
		ram_ctl.we    = 1'b0;
		ram_ctl.wdata = 1'b1;
		ram_ctl.waddr = ADDR_W'(py[7:0]) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(px[7:0]);
		ram_ctl.re    = 1'b0;
		ram_ctl.raddr = ram_ctl.waddr;
		case (state_q)
			ST_INIT, ST_CLR: begin
				ram_ctl.we    = 1'b1;
				ram_ctl.wdata = 1'b0;
				ram_ctl.waddr = clr_q;
				if (clr_last) state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (opcode)
						OP_HLINE, OP_VLINE, OP_RECT, OP_OUTLINE: state_d = ST_DRAW;
						OP_CLEAR: state_d = ST_CLR;
						OP_READ:  state_d = ST_RD;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_DRAW: begin
				ram_ctl.we = on_screen;
				if (ix_q == ex && iy_q == ey && last_seg) state_d = ST_DONE;
			end
			ST_RD: begin
				ram_ctl.re = on_screen;
				state_d    = on_screen ? ST_RDW : ST_DONE;
			end
			ST_RDW: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_INIT || state_q == ST_CLR) begin
				clr_q <= clr_last ? '0 : clr_q + 1'b1;
			end
			if (load_res) out_valid_q <= 1'b1;
			else if (out_take) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q      <= opcode;
			x_q       <= start_x;
			y_q       <= start_y;
			len_q     <= span_length;
			hgt_q     <= span_height;
			ix_q      <= '0;
			iy_q      <= '0;
			seg_q     <= '0;
			res_pix_q <= 1'b0;
			res_off_q <= 1'b0;
		end
		if (state_q == ST_DRAW) begin
			if (ix_q != ex) begin
				ix_q <= ix_q + 1'b1;
			end else begin
				ix_q <= '0;
				if (iy_q != ey) begin
					iy_q <= iy_q + 1'b1;
				end else begin
					iy_q  <= '0;
					seg_q <= seg_q + 1'b1;
				end
			end
		end
		if (state_q == ST_RD && !on_screen) res_off_q <= 1'b1;
		if (state_q == ST_RDW) res_pix_q <= rdata;
		if (load_res) begin
			read_pixel <= res_pix_q;
			off_screen <= res_off_q;
		end
	end

	assign out_valid = out_valid_q;

	lrf_frame_ram u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.rdata (rdata)
	);

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_ctl.we |-> (ram_ctl.waddr < ADDR_W'(FB_DEPTH)))
		else $error("frame write beyond store");

	a_no_wr_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_RDW) |-> !ram_ctl.we)
		else $error("write during pixel read");

	a_res_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(read_pixel && off_screen))
		else $error("pixel and off-screen both set");

	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result without finished request");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("request taken while busy");

endmodule

`default_nettype wire

>>> rtl/core/lrf_frame_ram.sv
`default_nettype none

module lrf_frame_ram
	import lrf_pkg::*;
(
	input  wire logic     clk,
	input  wire ram_ctl_t ctl,
	output logic          rdata
);

	logic mem [FB_DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		if (ctl.re) begin
			rdata <= mem[ctl.raddr];
		end
	end

endmodule

`default_nettype wire

>>> tb/lrf_checker.sv
`timescale 1ns / 100ps

module lrf_checker
	import lrf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [2:0] opcode,
	input  wire logic [7:0] start_x,
	input  wire logic [7:0] start_y,
	input  wire logic [7:0] span_length,
	input  wire logic [7:0] span_height,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic       read_pixel,
	input  wire logic       off_screen,
	output int              failures,
	output int              outstanding
);

	typedef struct packed {
		logic read_pixel;
		logic off_screen;
	} pixel_result_t;

	logic          frame_bits [SCREEN_HEIGHT][SCREEN_WIDTH];
	pixel_result_t pixel_result_q [$];

	task automatic paint_pixel(input int px, input int py);
		if (px < SCREEN_WIDTH && py < SCREEN_HEIGHT)
			frame_bits[py][px] = 1'b1;
	endtask

	task automatic paint_row(input int px, input int py, input int len);
		for (int i = 0; i <= len; i++)
			paint_pixel(px + i, py);
	endtask

	task automatic paint_column(input int px, input int py, input int hgt);
		for (int i = 0; i <= hgt; i++)
			paint_pixel(px, py + i);
	endtask

	task automatic wipe_frame();
		foreach (frame_bits[r, c])
			frame_bits[r][c] = 1'b0;
	endtask

	task automatic run_request(input logic [2:0] op, input int px, input int py,
			input int len, input int hgt, output pixel_result_t res);
		res = '0;
		case (op)
		OP_HLINE: paint_row(px, py, len);
		OP_VLINE: paint_column(px, py, hgt);
		OP_RECT: begin
			for (int i = 0; i <= hgt; i++)
				paint_row(px, py + i, len);
		end
		OP_OUTLINE: begin
			paint_row(px, py, len);
			paint_column(px + len, py, hgt);
			paint_row(px, py + hgt, len);
			paint_column(px, py, hgt);
		end
		OP_CLEAR: wipe_frame();
		OP_READ: begin
			if (px < SCREEN_WIDTH && py < SCREEN_HEIGHT)
				res.read_pixel = frame_bits[py][px];
			else
				res.off_screen = 1'b1;
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		pixel_result_t want;
		pixel_result_t got;
		if (!arst_n) begin
			wipe_frame();
			pixel_result_q.delete();
			failures = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.read_pixel = read_pixel;
				got.off_screen = off_screen;
				if (pixel_result_q.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: result with no request: read_pixel=%b off_screen=%b",
							$time, got.read_pixel, got.off_screen);
				end else begin
					want = pixel_result_q.pop_front();
					if (got.read_pixel !== want.read_pixel ||
							got.off_screen !== want.off_screen) begin
						failures++;
						if (failures <= 10)
							$display("%0t: expected pixel=%b off=%b, got pixel=%b off=%b",
								$time, want.read_pixel, want.off_screen,
								got.read_pixel, got.off_screen);
					end
				end
			end
			if (in_valid && !in_stall) begin
				run_request(opcode, int'(start_x), int'(start_y), int'(span_length),
					int'(span_height), want);
				pixel_result_q.push_back(want);
			end
			outstanding = pixel_result_q.size();
		end
	end

endmodule

>>> tb/line_and_rect_fill_engine_tb.sv
`timescale 1ns / 100ps

module line_and_rect_fill_engine_tb;
	import lrf_pkg::*;

	localparam logic [2:0] OP_SPARE_6  = 3'd6;
	localparam logic [2:0] OP_SPARE_7  = 3'd7;
	localparam int         QUIET_LIMIT = 400000;
	localparam int         TAIL_CYCLES = 100;
	localparam int         PHASE_ITEMS = 25;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic [2:0] opcode      = '0;
	logic [7:0] start_x     = '0;
	logic [7:0] start_y     = '0;
	logic [7:0] span_length = '0;
	logic [7:0] span_height = '0;
	logic       out_stall   = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic       read_pixel;
	logic       off_screen;
	int         failures;
	int         outstanding;

	int         send_idle_pct = 16;
	int         stall_pct     = 85;
	int         quiet_cycles  = 0;
	logic [7:0] anchor_x      = '0;
	logic [7:0] anchor_y      = '0;

	line_and_rect_fill_engine DUT (.*);

	lrf_checker CHECK (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_req(input logic [2:0] op, input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] len, input logic [7:0] hgt);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		start_x     <= x;
		start_y     <= y;
		span_length <= len;
		span_height <= hgt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold off the sender until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
	endtask

	task automatic send_random();
		int         pick;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] len;
		logic [7:0] hgt;
		pick = $urandom_range(0, 99);
		len  = 8'($urandom_range(0, 15));
		hgt  = 8'($urandom_range(0, 15));
		case ($urandom_range(0, 9))
		0: begin
			len = 8'($urandom_range(0, 255));
			hgt = 8'($urandom_range(0, 3));
		end
		1: begin
			hgt = 8'($urandom_range(0, 255));
			len = 8'($urandom_range(0, 3));
		end
		default: ;
		endcase
		if (pick < 45) begin
			if ($urandom_range(0, 7) == 0) begin
				x = 8'($urandom_range(0, 255));
				y = 8'($urandom_range(0, 255));
			end else begin
				x = 8'(anchor_x + $urandom_range(0, 20) - 2);
				y = 8'(anchor_y + $urandom_range(0, 20) - 2);
			end
			send_req(OP_READ, x, y, len, hgt);
		end else if (pick < 93) begin
			if ($urandom_range(0, 1) == 0) begin
				if ($urandom_range(0, 2) == 0) begin
					anchor_x = 8'($urandom_range(0, 255));
					anchor_y = 8'($urandom_range(0, 255));
				end else begin
					anchor_x = 8'($urandom_range(0, SCREEN_WIDTH - 1));
					anchor_y = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
				end
			end
			if (pick < 57)
				send_req(OP_HLINE, anchor_x, anchor_y, len, hgt);
			else if (pick < 69)
				send_req(OP_VLINE, anchor_x, anchor_y, len, hgt);
			else if (pick < 81)
				send_req(OP_RECT, anchor_x, anchor_y, len, hgt);
			else
				send_req(OP_OUTLINE, anchor_x, anchor_y, len, hgt);
		end else if (pick < 97) begin
			send_req(($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7,
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, hgt);
		end else begin
			send_req(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				len, hgt);
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// corners and just off the edges of a fresh frame
		send_req(OP_READ, 0, 0, 0, 0);
		send_req(OP_READ, 8'(SCREEN_WIDTH - 1), 8'(SCREEN_HEIGHT - 1), 8'hff, 8'hff);
		send_req(OP_READ, 8'(SCREEN_WIDTH), 0, 0, 0);
		send_req(OP_READ, 0, 8'(SCREEN_HEIGHT), 0, 0);
		send_req(OP_READ, 8'hff, 8'hff, 0, 0);
		// lines clipped at the right and bottom edges
		send_req(OP_HLINE, 190, 10, 20, 8'hff);
		send_req(OP_READ, 8'(SCREEN_WIDTH - 1), 10, 0, 0);
		send_req(OP_READ, 189, 10, 0, 0);
		send_req(OP_VLINE, 5, 140, 8'hff, 8'hff);
		send_req(OP_READ, 5, 8'(SCREEN_HEIGHT - 1), 0, 0);
		send_req(OP_READ, 5, 139, 0, 0);
		drain();
		send_req(OP_RECT, 50, 50, 3, 2);
		send_req(OP_READ, 53, 52, 0, 0);
		send_req(OP_READ, 54, 52, 0, 0);
		send_req(OP_OUTLINE, 100, 100, 10, 8);
		send_req(OP_READ, 105, 104, 0, 0);
		send_req(OP_READ, 110, 108, 0, 0);
		send_req(OP_OUTLINE, 195, 145, 10, 10);
		send_req(OP_READ, 195, 8'(SCREEN_HEIGHT - 1), 0, 0);
		send_req(OP_SPARE_6, 8'hff, 8'hff, 8'hff, 8'hff);
		send_req(OP_SPARE_7, 8'hff, 8'hff, 8'hff, 8'hff);
		send_req(OP_HLINE, 0, 0, 0, 0);
		send_req(OP_RECT, 0, 0, 8'hff, 8'hff);
		send_req(OP_READ, 123, 77, 0, 0);
		send_req(OP_CLEAR, 0, 0, 0, 0);
		send_req(OP_READ, 123, 77, 0, 0);
		repeat (PHASE_ITEMS) send_random();
		drain();

		send_idle_pct = 85;
		stall_pct     = 16;
		repeat (PHASE_ITEMS) send_random();
		drain();

		send_idle_pct = 0;
		stall_pct     = 0;
		repeat (PHASE_ITEMS) send_random();
		drain();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (failures == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
